FILE: rtl/core/spm_pkg.sv
// shared types and widths of the sparse polynomial multiplier
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

  localparam int COEF_W     = 32;
  localparam int EXPO_W     = 16;
  localparam int PCOEF_W    = 64;
  localparam int PEXPO_W    = 17;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 88;

  // polynomial selector carried on tuser
  localparam logic OP_FIRST_POLY  = 1'b0;
  localparam logic OP_SECOND_POLY = 1'b1;

  // one product term held in or moving along the sorting row
  typedef struct packed {
    logic                      vld;
    logic [PCOEF_W-1:0]        coef;
    logic signed [PEXPO_W-1:0] expo;
  } spm_term_t;

endpackage

`default_nettype wire

FILE: rtl/core/sparse_poly_multiply.sv
// top level of the sparse polynomial multiplier
// usage:
//   the input channel takes one term per beat: tuser = op (0 first, 1 second
//   polynomial), tdata = coefficient and exponent, tlast = last term.
//   terms beyond MAX_TERMS per polynomial are dropped. a beat with op 1 and
//   tlast set starts the multiply; in_tready stays low until it is done.
//   the multiply issues one term pair per cycle, each pair of loaded terms
//   once, through one 32x32 multiplier into a row of
//   MAX_TERMS*MAX_TERMS sorting cells, then waits in a drain state, as
//   long as the length of the cell row sets, for the row to settle.
//   results then leave the head of the row one per cycle unless stalled,
//   highest exponent first, with tlast on the lowest exponent; both
//   polynomials are cleared after it. an empty first polynomial gives
//   no results. loads run at one beat per cycle.
//   a stalled receiver holds the output register and the row waits.
//   reset empties both polynomials and the cell row and returns to loading.
`timescale 1ns / 1ps
`default_nettype none

module sparse_poly_multiply #(
  parameter int MAX_TERMS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [spm_pkg::IN_DATA_W-1:0]  in_tdata,   // coef[31:0], expo[47:32]
  input  wire logic                           in_tuser,   // op
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [spm_pkg::OUT_DATA_W-1:0]      out_tdata,  // prod_coef[63:0], prod_expo[80:64]
  output logic                                out_tlast
);
  import spm_pkg::*;

  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int DEPTH     = MAX_TERMS * MAX_TERMS;
  localparam int DRAIN_LEN = DEPTH + 1;
  localparam int DRN_W     = $clog2(DRAIN_LEN + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [COEF_W-1:0] first_coef_r  [MAX_TERMS];
  logic [EXPO_W-1:0] first_expo_r  [MAX_TERMS];
  logic [COEF_W-1:0] second_coef_r [MAX_TERMS];
  logic [EXPO_W-1:0] second_expo_r [MAX_TERMS];

  logic [CNT_W-1:0] first_cnt_r, first_cnt_nxt;
  logic [CNT_W-1:0] second_cnt_r, second_cnt_nxt;
  logic [IDX_W-1:0] a_r, a_nxt;
  logic [IDX_W-1:0] b_r, b_nxt;
  logic [DRN_W-1:0] drn_r, drn_nxt;

  spm_term_t prod_r, prod_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic               in_acc;
  logic               first_ld;
  logic               second_ld;
  logic               start;
  logic               a_end;
  logic               b_end;
  logic               emit_go;
  logic signed [PCOEF_W-1:0] mul_res;
  logic [COEF_W-1:0]  op_coef_a;
  logic [COEF_W-1:0]  op_coef_b;
  logic [EXPO_W-1:0]  op_expo_a;
  logic [EXPO_W-1:0]  op_expo_b;
  spm_term_t          head_term;
  logic               next_vld;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign first_ld  = in_acc && (in_tuser == OP_FIRST_POLY)
                   && (first_cnt_r < CNT_W'(MAX_TERMS));
  assign second_ld = in_acc && (in_tuser == OP_SECOND_POLY)
                   && (second_cnt_r < CNT_W'(MAX_TERMS));
  assign start     = in_acc && (in_tuser == OP_SECOND_POLY) && in_tlast;

  always_ff @(posedge clk) begin
    if (first_ld) begin
      first_coef_r[first_cnt_r[IDX_W-1:0]] <= in_tdata[COEF_W-1:0];
      first_expo_r[first_cnt_r[IDX_W-1:0]] <= in_tdata[COEF_W+EXPO_W-1:COEF_W];
    end
    if (second_ld) begin
      second_coef_r[second_cnt_r[IDX_W-1:0]] <= in_tdata[COEF_W-1:0];
      second_expo_r[second_cnt_r[IDX_W-1:0]] <= in_tdata[COEF_W+EXPO_W-1:COEF_W];
    end
  end

  assign op_coef_a = first_coef_r[a_r];
  assign op_coef_b = second_coef_r[b_r];
  assign op_expo_a = first_expo_r[a_r];
  assign op_expo_b = second_expo_r[b_r];
  assign mul_res   = $signed(op_coef_a) * $signed(op_coef_b);

  assign a_end   = (CNT_W'(a_r) + CNT_W'(1)) == first_cnt_r;
  assign b_end   = (CNT_W'(b_r) + CNT_W'(1)) == second_cnt_r;
  assign emit_go = (state_r == ST_EMIT) && head_term.vld && (!out_valid_r || out_tready);

  spm_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (emit_go),
    .ins_term  (prod_r),
    .head_term (head_term),
    .next_vld  (next_vld)
  );

  always_comb begin
    state_nxt      = state_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    drn_nxt        = drn_r;
    prod_nxt       = prod_r;
    prod_nxt.vld   = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (first_ld) begin
          first_cnt_nxt = first_cnt_r + CNT_W'(1);
        end
        if (second_ld) begin
          second_cnt_nxt = second_cnt_r + CNT_W'(1);
        end
        if (start) begin
          a_nxt = '0;
          b_nxt = '0;
          if (first_cnt_r == '0) begin
            first_cnt_nxt  = '0;
            second_cnt_nxt = '0;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt.vld  = 1'b1;
        prod_nxt.coef = mul_res;
        prod_nxt.expo = {op_expo_a[EXPO_W-1], op_expo_a}
                      + {op_expo_b[EXPO_W-1], op_expo_b};
        if (b_end) begin
          b_nxt = '0;
          a_nxt = a_r + IDX_W'(1);
          if (a_end) begin
            a_nxt     = '0;
            drn_nxt   = '0;
            state_nxt = ST_DRAIN;
          end
        end else begin
          b_nxt = b_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        drn_nxt = drn_r + DRN_W'(1);
        if (drn_r == DRN_W'(DRAIN_LEN - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W - PCOEF_W - PEXPO_W){1'b0}},
                           head_term.expo, head_term.coef};
          out_last_nxt  = !next_vld;
          if (!next_vld) begin
            first_cnt_nxt  = '0;
            second_cnt_nxt = '0;
            state_nxt      = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      a_r          <= '0;
      b_r          <= '0;
      drn_r        <= '0;
      prod_r.vld   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      drn_r        <= drn_nxt;
      prod_r       <= prod_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/spm_cell.sv
// one cell of the sorting row: keeps the larger exponent, merges equal ones
`timescale 1ns / 1ps
`default_nettype none

module spm_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift,
  input  wire spm_pkg::spm_term_t in_term,
  input  wire spm_pkg::spm_term_t nb_term,
  output spm_pkg::spm_term_t     hold_term,
  output spm_pkg::spm_term_t     pass_term
);
  import spm_pkg::*;

  spm_term_t hold_r, hold_nxt;
  spm_term_t pass_r, pass_nxt;

  always_comb begin
    hold_nxt     = hold_r;
    pass_nxt     = in_term;
    pass_nxt.vld = 1'b0;
    if (shift) begin
      hold_nxt = nb_term;
    end else if (in_term.vld) begin
      if (!hold_r.vld) begin
        hold_nxt = in_term;
      end else if ($signed(in_term.expo) > $signed(hold_r.expo)) begin
        hold_nxt = in_term;
        pass_nxt = hold_r;
      end else if (in_term.expo == hold_r.expo) begin
        hold_nxt.coef = hold_r.coef + in_term.coef;
      end else begin
        pass_nxt = in_term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r.vld <= 1'b0;
      pass_r.vld <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign hold_term = hold_r;
  assign pass_term = pass_r;

endmodule

`default_nettype wire

FILE: rtl/core/spm_chain.sv
// row of sorting cells: products enter at the head, results shift out of it
`timescale 1ns / 1ps
`default_nettype none

module spm_chain #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               shift,
  input  wire spm_pkg::spm_term_t  ins_term,
  output spm_pkg::spm_term_t      head_term,
  output logic                    next_vld
);
  import spm_pkg::*;

  spm_term_t hold_a [DEPTH];
  spm_term_t pass_a [DEPTH];
  spm_term_t left_a [DEPTH];
  spm_term_t right_a [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_a[i] = ins_term;
    end else begin : g_mid
      assign left_a[i] = pass_a[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_a[i] = '0;
    end else begin : g_inner
      assign right_a[i] = hold_a[i+1];
    end

    spm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (shift),
      .in_term   (left_a[i]),
      .nb_term   (right_a[i]),
      .hold_term (hold_a[i]),
      .pass_term (pass_a[i])
    );
  end

  assign head_term = hold_a[0];

  if (DEPTH > 1) begin : g_next
    assign next_vld = hold_a[1].vld;
  end else begin : g_single
    assign next_vld = 1'b0;
  end

endmodule

`default_nettype wire
